// ----- hdl/enmt_pkg.sv -----
// Shared constants, types and control structures of the neighbour message table.
`timescale 1ns / 1ps
package enmt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [15:0] NONE_INDEX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_AGE    = 3'd1,
    OP_SUB    = 3'd2,
    OP_ERASE  = 3'd3,
    OP_SELECT = 3'd4,
    OP_MARK   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    UPD_IGNORED   = 2'd0,
    UPD_APPENDED  = 2'd1,
    UPD_REFRESHED = 2'd2
  } upd_t;

  typedef struct packed {
    logic [7:0]       agent;
    logic [7:0]       state;
    logic [31:0]      counter;
    logic [7:0]       hops;
    logic             delivered;
    logic [IDX_W-1:0] rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Source of the table write data.
  typedef enum logic [2:0] {
    WD_A,        // read port A as is
    WD_B,        // read port B as is
    WD_NEW,      // fresh entry from the request
    WD_REFRESH,  // matched entry refreshed from the request
    WD_RANKDEC,  // port A with its arrival rank lowered by one
    WD_AGE,      // port A counter plus one
    WD_SUB,      // port A counter minus ticks, floored at zero
    WD_MARK      // port A marked delivered
  } wsel_t;

  typedef struct packed {
    logic             item_ready;
    logic             re;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic             we;
    logic [IDX_W-1:0] waddr;
    wsel_t            wsel;
    logic             v_swap;
    logic             v_clr0;
    logic             v_set;
    logic             v_prefix;
    logic [CNT_W-1:0] w;
    logic             occ_inc;
    logic             occ_dec;
    logic             find_clr;
    logic             find_load;
    logic             rank_load;
    logic             dist_clr;
    logic             dist_inc;
    logic             upd_load;
    upd_t             upd;
    logic             sel_load;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic             item_valid;
    op_t              op;
    logic             expiry;
    logic             match;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] occ;
    logic             ps_lt_n;
    logic [IDX_W-1:0] ps_idx;
    logic             a_valid;
    logic             b_valid;
    logic             a_gt_b;
    logic             agent_hit;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             refresh_ok;
    logic             eligible;
    logic             valid0;
    logic             ctr_nz;
    logic             ctr_max;
    logic             rank_gt;
    logic             dup_agent;
    logic             mark_ok;
    logic [IDX_W-1:0] mark_idx;
    logic             out_free;
  } sts_t;

endpackage

// ----- hdl/enmt_if.sv -----
// Channel interfaces of the neighbour message table: requests, results and configuration.
`timescale 1ns / 1ps
interface enmt_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  sender_id;
  logic [7:0]  sender_state;
  logic [31:0] expiry_time;
  logic [7:0]  hops;
  logic        gossip;
  logic [31:0] ticks;
  logic        check_hops;
  logic [7:0]  entry_index;
  modport source (output valid, operation, sender_id, sender_state, expiry_time, hops,
                  gossip, ticks, check_hops, entry_index, input ready);
  modport sink (input valid, operation, sender_id, sender_state, expiry_time, hops,
                gossip, ticks, check_hops, entry_index, output ready);
endinterface

interface enmt_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  update_result;
  logic [15:0] selected_index;
  logic [7:0]  distinct_agents;
  logic [4:0]  entry_count;
  modport source (output valid, update_result, selected_index, distinct_agents, entry_count,
                  input ready);
  modport sink (input valid, update_result, selected_index, distinct_agents, entry_count,
                output ready);
endinterface

interface enmt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [enmt_pkg::CFG_IDX_W-1:0]   index;
  logic [enmt_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/enmt_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module enmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/enmt_ctl.sv -----
// Sequencer of the neighbour message table: walks the table for most operations.
`timescale 1ns / 1ps
module enmt_ctl (
  input  logic            clk,
  input  logic            rst,
  input  enmt_pkg::sts_t  st,
  output enmt_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MRD, S_MCHK, S_MDEC, S_INS, S_APP, S_RO, S_SRD, S_SCMP, S_SWR,
    S_CRD, S_CCHK, S_CFIN, S_DC0, S_DRD, S_DCHK, S_RET, S_RM, S_RM1, S_RMRD, S_RMCHK,
    S_ER, S_ERRD, S_ERCHK, S_URD, S_UCHK, S_SLRD, S_SLCHK, S_MKRD, S_MKWR, S_FIN
  } state_t;

  // Where a shared reorder or removal goes back to.
  typedef enum logic [2:0] {
    C_INS1, C_INS2, C_INS3, C_ER1, C_ER2, C_ER3
  } cont_t;

  state_t                      state, state_next;
  cont_t                       cont, cont_next;
  logic [enmt_pkg::IDX_W-1:0]  i, i_next, j, j_next;
  logic [enmt_pkg::CNT_W-1:0]  w, w_next;
  logic                        last_i_c, last_i_n, last_j, last_i_pair, swap;

  assign last_i_c    = (enmt_pkg::CNT_W'(i) == st.c - enmt_pkg::CNT_W'(1));
  assign last_i_n    = (enmt_pkg::CNT_W'(i) == st.n - enmt_pkg::CNT_W'(1));
  assign last_j      = (enmt_pkg::CNT_W'(j) == st.c - enmt_pkg::CNT_W'(1));
  assign last_i_pair = (enmt_pkg::CNT_W'(i) == st.c - enmt_pkg::CNT_W'(2));
  assign swap        = (!st.a_valid && st.b_valid) || (st.a_valid && st.b_valid && st.a_gt_b);

  always_comb begin
    cmd        = '0;
    cmd.wsel   = enmt_pkg::WD_A;
    cmd.upd    = enmt_pkg::UPD_IGNORED;
    cmd.addr_a = i;
    cmd.addr_b = j;
    cmd.waddr  = i;
    cmd.w      = w;
    state_next = state;
    cont_next  = cont;
    i_next     = i;
    j_next     = j;
    w_next     = w;
    unique case (state)
      S_IDLE: begin
        cmd.item_ready = 1'b1;
        if (st.item_valid) state_next = S_DISP;
      end
      S_DISP: begin
        i_next = '0;
        unique case (st.op)
          enmt_pkg::OP_INSERT: begin
            cmd.find_clr = 1'b1;
            state_next = st.match ? S_MRD : S_INS;
          end
          enmt_pkg::OP_AGE, enmt_pkg::OP_SUB: begin
            state_next = (st.n == '0) ? S_FIN : S_URD;
          end
          enmt_pkg::OP_ERASE: state_next = st.expiry ? S_ER : S_FIN;
          enmt_pkg::OP_SELECT: begin
            if (st.n == '0 || !st.ps_lt_n) begin
              state_next = S_FIN;
            end else begin
              i_next = st.expiry ? enmt_pkg::IDX_W'(st.n - enmt_pkg::CNT_W'(1)) : st.ps_idx;
              state_next = S_SLRD;
            end
          end
          enmt_pkg::OP_MARK: state_next = st.mark_ok ? S_MKRD : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_MRD: begin
        cmd.re = 1'b1;
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (st.agent_hit) cmd.find_load = 1'b1;
        if (last_i_c) begin
          state_next = S_MDEC;
        end else begin
          i_next = i + 1'b1;
          state_next = S_MRD;
        end
      end
      S_MDEC: begin
        if (st.found) begin
          if (st.refresh_ok) begin
            cmd.we       = 1'b1;
            cmd.waddr    = st.found_idx;
            cmd.wsel     = enmt_pkg::WD_REFRESH;
            cmd.upd_load = 1'b1;
            cmd.upd      = enmt_pkg::UPD_REFRESHED;
          end
          state_next = S_FIN;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        if (st.occ >= st.c) begin
          cont_next  = C_INS1;
          state_next = S_RO;
        end else begin
          state_next = S_APP;
        end
      end
      S_APP: begin
        if (st.occ < st.c) begin
          cmd.we       = 1'b1;
          cmd.waddr    = enmt_pkg::IDX_W'(st.occ);
          cmd.wsel     = enmt_pkg::WD_NEW;
          cmd.v_set    = 1'b1;
          cmd.occ_inc  = 1'b1;
          cmd.upd_load = 1'b1;
          cmd.upd      = enmt_pkg::UPD_APPENDED;
        end
        state_next = S_FIN;
      end
      S_RO: begin
        i_next = '0;
        if (st.expiry) begin
          j_next     = enmt_pkg::IDX_W'(1);
          state_next = (st.c < enmt_pkg::CNT_W'(2)) ? S_DC0 : S_SRD;
        end else begin
          w_next     = '0;
          state_next = S_CRD;
        end
      end
      S_SRD: begin
        cmd.re = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP, S_SWR: begin
        if (state == S_SWR) begin
          cmd.we    = 1'b1;
          cmd.waddr = j;
        end else if (swap) begin
          cmd.we     = 1'b1;
          cmd.wsel   = enmt_pkg::WD_B;
          cmd.v_swap = 1'b1;
        end
        if (state == S_SCMP && swap) begin
          state_next = S_SWR;
        end else if (last_j) begin
          if (last_i_pair) begin
            state_next = S_DC0;
          end else begin
            i_next     = i + 1'b1;
            j_next     = i + enmt_pkg::IDX_W'(2);
            state_next = S_SRD;
          end
        end else begin
          j_next     = j + 1'b1;
          state_next = S_SRD;
        end
      end
      S_CRD: begin
        cmd.re = 1'b1;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        if (st.a_valid) begin
          if (w != enmt_pkg::CNT_W'(i)) begin
            cmd.we    = 1'b1;
            cmd.waddr = enmt_pkg::IDX_W'(w);
          end
          w_next = w + 1'b1;
        end
        if (last_i_c) begin
          state_next = S_CFIN;
        end else begin
          i_next = i + 1'b1;
          state_next = S_CRD;
        end
      end
      S_CFIN: begin
        cmd.v_prefix = 1'b1;
        state_next = S_DC0;
      end
      // Distinct count: entry i counts when no earlier entry j carries the same agent.
      S_DC0: begin
        cmd.dist_clr = 1'b1;
        i_next = '0;
        j_next = '0;
        state_next = (st.n == '0) ? S_RET : S_DRD;
      end
      S_DRD: begin
        cmd.re = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (j == i || st.dup_agent) begin
          if (j == i && st.a_valid) cmd.dist_inc = 1'b1;
          if (last_i_n) begin
            state_next = S_RET;
          end else begin
            i_next = i + 1'b1;
            j_next = '0;
            state_next = S_DRD;
          end
        end else begin
          j_next = j + 1'b1;
          state_next = S_DRD;
        end
      end
      S_RET: begin
        unique case (cont)
          C_INS1: begin
            cont_next  = C_INS2;
            state_next = S_RM;
          end
          C_INS2: begin
            cont_next  = C_INS3;
            state_next = S_RO;
          end
          C_INS3: state_next = S_APP;
          C_ER1: state_next = st.valid0 ? S_ERRD : S_FIN;
          C_ER2: begin
            cont_next  = C_ER3;
            state_next = S_RO;
          end
          C_ER3: state_next = S_ER;
          default: state_next = S_FIN;
        endcase
      end
      S_RM: begin
        if (st.valid0) begin
          cmd.addr_a = '0;
          cmd.re     = 1'b1;
          state_next = S_RM1;
        end else begin
          state_next = S_RET;
        end
      end
      S_RM1: begin
        cmd.rank_load = 1'b1;
        cmd.v_clr0    = 1'b1;
        cmd.occ_dec   = 1'b1;
        i_next = '0;
        state_next = S_RMRD;
      end
      S_RMRD: begin
        cmd.re = 1'b1;
        state_next = S_RMCHK;
      end
      S_RMCHK: begin
        if (st.rank_gt) begin
          cmd.we   = 1'b1;
          cmd.wsel = enmt_pkg::WD_RANKDEC;
        end
        if (last_i_c) begin
          state_next = S_RET;
        end else begin
          i_next = i + 1'b1;
          state_next = S_RMRD;
        end
      end
      S_ER: begin
        if (st.occ == '0) begin
          state_next = S_FIN;
        end else if (!st.valid0) begin
          cont_next  = C_ER1;
          state_next = S_RO;
        end else begin
          state_next = S_ERRD;
        end
      end
      S_ERRD: begin
        cmd.addr_a = '0;
        cmd.re     = 1'b1;
        state_next = S_ERCHK;
      end
      S_ERCHK: begin
        if (st.ctr_nz) begin
          state_next = S_FIN;
        end else begin
          cont_next  = C_ER2;
          state_next = S_RM;
        end
      end
      S_URD: begin
        cmd.re = 1'b1;
        state_next = S_UCHK;
      end
      S_UCHK: begin
        if (st.op == enmt_pkg::OP_AGE) begin
          cmd.we   = st.a_valid && !st.ctr_max;
          cmd.wsel = enmt_pkg::WD_AGE;
        end else begin
          cmd.we   = st.a_valid;
          cmd.wsel = enmt_pkg::WD_SUB;
        end
        if (last_i_n) begin
          state_next = S_FIN;
        end else begin
          i_next = i + 1'b1;
          state_next = S_URD;
        end
      end
      S_SLRD: begin
        cmd.re = 1'b1;
        state_next = S_SLCHK;
      end
      S_SLCHK: begin
        if (st.eligible) begin
          cmd.sel_load = 1'b1;
          state_next = S_FIN;
        end else if (st.expiry) begin
          if (i == st.ps_idx) begin
            state_next = S_FIN;
          end else begin
            i_next = i - 1'b1;
            state_next = S_SLRD;
          end
        end else if (last_i_n) begin
          state_next = S_FIN;
        end else begin
          i_next = i + 1'b1;
          state_next = S_SLRD;
        end
      end
      S_MKRD: begin
        cmd.addr_a = st.mark_idx;
        cmd.re     = 1'b1;
        state_next = S_MKWR;
      end
      S_MKWR: begin
        cmd.we    = 1'b1;
        cmd.waddr = st.mark_idx;
        cmd.wsel  = enmt_pkg::WD_MARK;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cont  <= C_INS1;
      i     <= '0;
      j     <= '0;
      w     <= '0;
    end else begin
      state <= state_next;
      cont  <= cont_next;
      i     <= i_next;
      j     <= j_next;
      w     <= w_next;
    end
  end

  // A new request is only taken once the previous one has been finished.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (st.item_valid && cmd.item_ready) |=> !cmd.item_ready)
    else $error("request taken while another is in progress");

  // The second half of a swap always follows a swap decision.
  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWR) |-> $past(cmd.v_swap))
    else $error("swap completion without a swap");

endmodule

// ----- hdl/enmt_dp.sv -----
// Datapath of the neighbour message table: table memory, flags, counts and result register.
`timescale 1ns / 1ps
module enmt_dp (
  input  logic              clk,
  input  logic              rst,
  enmt_item_if.sink         item,
  enmt_result_if.source     result,
  enmt_cfg_if.sink          cfg,
  input  enmt_pkg::cmd_t    cmd,
  output enmt_pkg::sts_t    st
);

  // Configuration.
  logic                        expiry_enabled, match_by_agent;
  logic [7:0]                  priority_start;
  logic [enmt_pkg::CAP_W-1:0]  capacity_in_use;
  logic [enmt_pkg::CNT_W-1:0]  c, n;
  logic                        cfg_wr, cap_wr;

  // Request held for the duration of the operation.
  logic [2:0]  op_q;
  logic [7:0]  agent_q, state_q, hops_q, index_q;
  logic [31:0] expiry_q, ticks_q;
  logic        gossip_q, check_q;

  // Table state.
  logic [enmt_pkg::MAX_ENTRIES-1:0] valid, prefix_mask, cap_mask;
  logic [enmt_pkg::CNT_W-1:0]       occ;
  logic [7:0]                       distinct;
  enmt_pkg::entry_t                 rd_a, rd_b, wd;

  // Search and removal scratch.
  logic                        found;
  logic [enmt_pkg::IDX_W-1:0]  found_idx, best, rank_r;
  enmt_pkg::entry_t            stash;

  // Result.
  enmt_pkg::upd_t              upd_r;
  logic [15:0]                 sel_r;
  logic                        out_valid;
  enmt_pkg::upd_t              out_upd;
  logic [15:0]                 out_sel;
  logic [7:0]                  out_distinct;
  logic [enmt_pkg::CNT_W-1:0]  out_count;
  logic                        accept;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cap_wr    = cfg_wr && (cfg.index == enmt_pkg::CFG_CAPACITY);
  assign item.ready = cmd.item_ready;
  assign accept    = item.valid && cmd.item_ready;

  always_comb begin
    if (capacity_in_use == '0) begin
      c = enmt_pkg::CNT_W'(1);
    end else if (enmt_pkg::CNT_W'(capacity_in_use) > enmt_pkg::CNT_W'(enmt_pkg::MAX_ENTRIES)) begin
      c = enmt_pkg::CNT_W'(enmt_pkg::MAX_ENTRIES);
    end else begin
      c = enmt_pkg::CNT_W'(capacity_in_use);
    end
    n = (occ < c) ? occ : c;
  end

  always_comb begin
    for (int k = 0; k < enmt_pkg::MAX_ENTRIES; k++) begin
      prefix_mask[k] = (enmt_pkg::CNT_W'(k) < cmd.w);
      cap_mask[k]    = (enmt_pkg::CNT_W'(k) < c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_enabled  <= 1'b0;
      match_by_agent  <= 1'b0;
      priority_start  <= '0;
      capacity_in_use <= enmt_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        enmt_pkg::CFG_EXPIRY:   expiry_enabled  <= cfg.data[0];
        enmt_pkg::CFG_MATCH:    match_by_agent  <= cfg.data[0];
        enmt_pkg::CFG_PRIORITY: priority_start  <= cfg.data;
        enmt_pkg::CFG_CAPACITY: capacity_in_use <= cfg.data[enmt_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= item.operation;
      agent_q  <= item.sender_id;
      state_q  <= item.sender_state;
      expiry_q <= item.expiry_time;
      hops_q   <= item.hops;
      gossip_q <= item.gossip;
      ticks_q  <= item.ticks;
      check_q  <= item.check_hops;
      index_q  <= item.entry_index;
    end
  end

  always_comb begin
    wd = rd_a;
    case (cmd.wsel)
      enmt_pkg::WD_A: wd = rd_a;
      enmt_pkg::WD_B: wd = rd_b;
      enmt_pkg::WD_NEW: begin
        wd.agent     = agent_q;
        wd.state     = state_q;
        wd.counter   = expiry_q;
        wd.hops      = hops_q;
        wd.delivered = 1'b0;
        wd.rank      = cmd.waddr;
      end
      enmt_pkg::WD_REFRESH: begin
        wd           = stash;
        wd.counter   = expiry_q;
        wd.state     = state_q;
        wd.hops      = hops_q;
        wd.delivered = 1'b0;
      end
      enmt_pkg::WD_RANKDEC: wd.rank = rd_a.rank - 1'b1;
      enmt_pkg::WD_AGE: wd.counter = rd_a.counter + 32'd1;
      enmt_pkg::WD_SUB: wd.counter = (rd_a.counter > ticks_q) ? rd_a.counter - ticks_q : '0;
      enmt_pkg::WD_MARK: wd.delivered = 1'b1;
      default: wd = rd_a;
    endcase
  end

  enmt_ram #(
    .WIDTH (enmt_pkg::ENTRY_W),
    .DEPTH (enmt_pkg::MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (cmd.we),
    .waddr   (cmd.waddr),
    .wdata   (wd),
    .re      (cmd.re),
    .raddr_a (cmd.addr_a),
    .raddr_b (cmd.addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cap_wr) begin
      valid <= '0;
    end else if (cmd.v_prefix) begin
      valid <= prefix_mask;
    end else begin
      if (cmd.v_swap) begin
        valid[cmd.addr_a] <= valid[cmd.addr_b];
        valid[cmd.addr_b] <= valid[cmd.addr_a];
      end
      if (cmd.v_clr0) valid[0] <= 1'b0;
      if (cmd.v_set) valid[cmd.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      distinct <= '0;
    end else if (cap_wr) begin
      occ      <= '0;
      distinct <= '0;
    end else begin
      if (cmd.occ_inc) occ <= occ + 1'b1;
      else if (cmd.occ_dec && occ != '0) occ <= occ - 1'b1;
      if (cmd.dist_clr) begin
        distinct <= '0;
      end else if (cmd.dist_inc) begin
        distinct <= distinct + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_clr) begin
      found <= 1'b0;
    end else if (cmd.find_load) begin
      found     <= 1'b1;
      found_idx <= cmd.addr_a;
      best      <= rd_a.rank;
      stash     <= rd_a;
    end
    if (cmd.rank_load) rank_r <= rd_a.rank;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd_r <= enmt_pkg::UPD_IGNORED;
      sel_r <= enmt_pkg::NONE_INDEX;
    end else begin
      if (cmd.upd_load) upd_r <= cmd.upd;
      if (cmd.sel_load) sel_r <= 16'(cmd.addr_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_upd      <= upd_r;
      out_sel      <= sel_r;
      out_distinct <= distinct;
      out_count    <= occ;
    end
  end

  assign result.valid           = out_valid;
  assign result.update_result   = out_upd;
  assign result.selected_index  = out_sel;
  assign result.distinct_agents = out_distinct;
  assign result.entry_count     = out_count;

  always_comb begin
    st            = '0;
    st.item_valid = item.valid;
    st.op         = enmt_pkg::op_t'(op_q);
    st.expiry     = expiry_enabled;
    st.match      = match_by_agent;
    st.c          = c;
    st.n          = n;
    st.occ        = occ;
    st.ps_lt_n    = (8'(n) > priority_start);
    st.ps_idx     = priority_start[enmt_pkg::IDX_W-1:0];
    st.a_valid    = valid[cmd.addr_a];
    st.b_valid    = valid[cmd.addr_b];
    st.a_gt_b     = rd_a.counter > rd_b.counter;
    st.agent_hit  = valid[cmd.addr_a] && (rd_a.agent == agent_q) && (!found || rd_a.rank < best);
    st.found      = found;
    st.found_idx  = found_idx;
    st.refresh_ok = (state_q != stash.state) && (!gossip_q || hops_q <= stash.hops);
    st.eligible   = valid[cmd.addr_a] && !rd_a.delivered && (!check_q || rd_a.hops != '0);
    st.valid0     = valid[0];
    st.ctr_nz     = rd_a.counter != '0;
    st.ctr_max    = &rd_a.counter;
    st.rank_gt    = valid[cmd.addr_a] && (rd_a.rank > rank_r);
    st.dup_agent  = valid[cmd.addr_a] && valid[cmd.addr_b] && (rd_a.agent == rd_b.agent);
    st.mark_ok    = (8'(c) > index_q) && valid[index_q[enmt_pkg::IDX_W-1:0]];
    st.mark_idx   = index_q[enmt_pkg::IDX_W-1:0];
    st.out_free   = !out_valid || result.ready;
  end

  a_occ_cap: assert property (@(posedge clk) disable iff (rst) occ <= c)
    else $error("occupancy above capacity");

  a_valid_cap: assert property (@(posedge clk) disable iff (rst) (valid & ~cap_mask) == '0)
    else $error("entry valid beyond capacity");

  // Between requests the valid entries match the count and entry 0 is valid unless empty.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    cmd.item_ready |-> ($countones(valid) == 32'(occ)) && (valid[0] || occ == '0))
    else $error("occupied entries do not match the count");

endmodule

// ----- hdl/expiring_neighbour_message_table.sv -----
// Top level of the expiring neighbour message table.
`timescale 1ns / 1ps
//  channel  direction  handshake       contents
//  item     in         valid / ready   operation and its operands
//  result   out        valid / ready   update result, selected index, counts
//  cfg      in         valid / ready   register index and write data
//
// Each request is worked through by a sequencer over a 16-entry table memory
// with two read ports; one request is in progress at a time. A table sweep reads
// each entry and then checks it (ageing, ticks, selection and the agent search).
// With expiry on, a reorder is the exchange sort: c*(c-1)/2 compare steps, each
// reading a pair of entries and, where a swap is needed, writing both; with expiry
// off it compacts the occupied entries to the front. Either is followed by a
// distinct-agent count that compares each of the first n entries with those
// before it. Inserting into a full table runs two reorders and a removal sweep;
// erasing runs one removal and one reorder per expired entry. Mark reads the
// entry and writes it back marked; unknown operations go straight to the result.
// Reset is synchronous and leaves the table empty with the capacity at sixteen.
// The result sits in an output register, so a new request is taken while the
// previous result is still waiting; a request only completes once that register
// is free. Configuration writes are always taken and act from the next cycle.
module expiring_neighbour_message_table (
  input  logic           clk,
  input  logic           rst,
  enmt_item_if.sink      item,
  enmt_result_if.source  result,
  enmt_cfg_if.sink       cfg
);

  enmt_pkg::cmd_t cmd;
  enmt_pkg::sts_t st;

  // The sequencer decides, the datapath holds all table and result state.
  enmt_ctl u_ctl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  enmt_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

// ----- test/enmt_tb_scoreboard.sv -----
// Scoreboard of the neighbour message table: a table predictor and a queue of expected results.
`timescale 1ns / 1ps
class enmt_table_scoreboard;

  typedef struct packed {
    logic [1:0]  upd;
    logic [15:0] sel;
    logic [7:0]  distinct;
    logic [4:0]  count;
  } outcome_t;

  bit          expiry_on;
  bit          match_on;
  bit [7:0]    prio_start;
  bit [4:0]    capacity;

  bit          v[16];
  bit [7:0]    ag[16];
  bit [7:0]    st[16];
  bit [31:0]   ctr[16];
  bit [7:0]    hp[16];
  bit          dl[16];
  int unsigned rk[16];
  int unsigned occupied;
  int unsigned distinct;

  outcome_t    pending[$];
  int          errors;

  function new();
    expiry_on = 0;
    match_on = 0;
    prio_start = 0;
    capacity = 16;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < 16; i++) begin
      v[i] = 0; ag[i] = 0; st[i] = 0; ctr[i] = 0; hp[i] = 0; dl[i] = 0; rk[i] = 0;
    end
    occupied = 0;
    distinct = 0;
  endfunction

  function int unsigned slots();
    if (capacity == 0) return 1;
    if (capacity > 16) return 16;
    return capacity;
  endfunction

  function void write_reg(logic [7:0] idx, logic [7:0] data);
    case (idx)
      enmt_pkg::CFG_EXPIRY:   expiry_on = data[0];
      enmt_pkg::CFG_MATCH:    match_on = data[0];
      enmt_pkg::CFG_PRIORITY: prio_start = data;
      enmt_pkg::CFG_CAPACITY: begin
        capacity = data[4:0];
        wipe();
      end
      default: ;
    endcase
  endfunction

  function void swap(int a, int b);
    bit tv; bit [7:0] ta, ts, th; bit [31:0] tc; bit td; int unsigned tr;
    tv = v[a]; ta = ag[a]; ts = st[a]; tc = ctr[a]; th = hp[a]; td = dl[a]; tr = rk[a];
    v[a] = v[b]; ag[a] = ag[b]; st[a] = st[b]; ctr[a] = ctr[b]; hp[a] = hp[b];
    dl[a] = dl[b]; rk[a] = rk[b];
    v[b] = tv; ag[b] = ta; st[b] = ts; ctr[b] = tc; hp[b] = th; dl[b] = td; rk[b] = tr;
  endfunction

  function void reorder();
    int unsigned c, w;
    bit seen[256];
    c = slots();
    distinct = 0;
    if (expiry_on) begin
      for (int i = 0; i + 1 < c; i++)
        for (int j = i + 1; j < c; j++)
          if ((!v[i] && v[j]) || (v[i] && v[j] && ctr[i] > ctr[j])) swap(i, j);
    end else begin
      w = 0;
      for (int i = 0; i < c; i++)
        if (v[i]) begin
          if (w != i) begin
            v[w] = v[i]; ag[w] = ag[i]; st[w] = st[i]; ctr[w] = ctr[i];
            hp[w] = hp[i]; dl[w] = dl[i]; rk[w] = rk[i];
          end
          w++;
        end
      for (int i = w; i < c; i++) v[i] = 0;
    end
    for (int i = 0; i < 256; i++) seen[i] = 0;
    for (int i = 0; i < occupied && i < c; i++)
      if (v[i] && !seen[ag[i]]) begin
        seen[ag[i]] = 1;
        distinct++;
      end
  endfunction

  function void drop_front();
    int unsigned r;
    if (!v[0]) return;
    r = rk[0];
    v[0] = 0;
    for (int i = 0; i < slots(); i++)
      if (v[i] && rk[i] > r) rk[i]--;
    if (occupied > 0) occupied--;
  endfunction

  function logic [1:0] insert_entry(bit [7:0] a, bit [7:0] s, bit [31:0] t, bit [7:0] h,
                                    bit g);
    int unsigned c, found, best, n;
    c = slots();
    found = c;
    best = 0;
    if (match_on) begin
      for (int i = 0; i < c; i++)
        if (v[i] && ag[i] == a && (found == c || rk[i] < best)) begin
          found = i;
          best = rk[i];
        end
      if (found < c) begin
        if (s != st[found] && (!g || h <= hp[found])) begin
          ctr[found] = t; st[found] = s; dl[found] = 0; hp[found] = h;
          return enmt_pkg::UPD_REFRESHED;
        end
        return enmt_pkg::UPD_IGNORED;
      end
    end
    if (occupied >= c) begin
      reorder();
      drop_front();
      reorder();
    end
    if (occupied >= c) return enmt_pkg::UPD_IGNORED;
    n = occupied;
    v[n] = 1; ag[n] = a; st[n] = s; ctr[n] = t; hp[n] = h; dl[n] = 0; rk[n] = n;
    occupied++;
    return enmt_pkg::UPD_APPENDED;
  endfunction

  function bit can_pick(int i, bit chk);
    if (!v[i] || dl[i]) return 0;
    return !chk || hp[i] > 0;
  endfunction

  function logic [15:0] pick(bit chk);
    int unsigned n;
    n = occupied > slots() ? slots() : occupied;
    if (n == 0 || prio_start >= n) return enmt_pkg::NONE_INDEX;
    if (!expiry_on) begin
      for (int i = prio_start; i < n; i++) if (can_pick(i, chk)) return 16'(i);
    end else begin
      for (int i = n; i > prio_start; i--) if (can_pick(i - 1, chk)) return 16'(i - 1);
    end
    return enmt_pkg::NONE_INDEX;
  endfunction

  // Notes one accepted request and queues the result it must produce.
  function void note_request(logic [2:0] op, logic [7:0] a, logic [7:0] s, logic [31:0] t,
                             logic [7:0] h, logic g, logic [31:0] tk, logic chk,
                             logic [7:0] k);
    outcome_t o;
    int unsigned c, n;
    c = slots();
    n = occupied < c ? occupied : c;
    o.upd = enmt_pkg::UPD_IGNORED;
    o.sel = enmt_pkg::NONE_INDEX;
    case (op)
      enmt_pkg::OP_INSERT: o.upd = insert_entry(a, s, t, h, g);
      enmt_pkg::OP_AGE:
        for (int i = 0; i < n; i++) if (v[i] && ctr[i] != 32'hFFFF_FFFF) ctr[i]++;
      enmt_pkg::OP_SUB:
        for (int i = 0; i < n; i++) if (v[i]) ctr[i] = ctr[i] > tk ? ctr[i] - tk : 0;
      enmt_pkg::OP_ERASE:
        if (expiry_on)
          while (occupied > 0) begin
            if (!v[0]) begin
              reorder();
              if (!v[0]) break;
            end
            if (ctr[0] > 0) break;
            drop_front();
            reorder();
          end
      enmt_pkg::OP_SELECT: o.sel = pick(chk);
      enmt_pkg::OP_MARK: if (k < c && v[k]) dl[k] = 1;
      default: ;
    endcase
    o.distinct = distinct[7:0];
    o.count = occupied[4:0];
    pending.push_back(o);
  endfunction

  function void check_result(logic [1:0] u, logic [15:0] sel, logic [7:0] d, logic [4:0] cnt);
    outcome_t o;
    if (pending.size() == 0) begin
      $error("unexpected result: update_result %0d selected_index %0d", u, sel);
      errors++;
      return;
    end
    o = pending.pop_front();
    if (u !== o.upd) begin
      $error("update_result: expected %0d, got %0d", o.upd, u); errors++;
    end
    if (sel !== o.sel) begin
      $error("selected_index: expected %0d, got %0d", o.sel, sel); errors++;
    end
    if (d !== o.distinct) begin
      $error("distinct_agents: expected %0d, got %0d", o.distinct, d); errors++;
    end
    if (cnt !== o.count) begin
      $error("entry_count: expected %0d, got %0d", o.count, cnt); errors++;
    end
  endfunction

endclass

// ----- test/expiring_neighbour_message_table_tb.sv -----
// Testbench of the expiring neighbour message table, checked against a table predictor.
`timescale 1ns / 1ps
module expiring_neighbour_message_table_tb;

  logic clk;
  logic rst;
  enmt_item_if   item ();
  enmt_result_if result ();
  enmt_cfg_if    cfg ();

  expiring_neighbour_message_table dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  enmt_table_scoreboard table_model;
  longint unsigned cycle_count;
  bit stall_heavy;
  // Agent ids are drawn from a small pool most of the time so that refreshes happen.
  logic [7:0] agent_pool[4];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Results are sampled at the rising edge; the stall pattern changes at the falling edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && result.valid && result.ready)
      table_model.check_result(result.update_result, result.selected_index,
                               result.distinct_agents, result.entry_count);
  end

  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (stall_heavy) result.ready <= ($urandom_range(0, 3) == 0);
    else result.ready <= ($urandom_range(0, 7) != 0);
  end

  // The watchdog allows several times the slowest correct run: 800-odd requests, each of
  // which can be an erase that empties a full table entry by entry.
  always @(posedge clk) begin
    if (cycle_count > 50_000_000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    table_model.write_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Sends one request; valid stays high until the handshake and is lowered only afterwards.
  task automatic send_request(logic [2:0] op, logic [7:0] a, logic [7:0] s, logic [31:0] t,
                              logic [7:0] h, logic g, logic [31:0] tk, logic chk,
                              logic [7:0] k);
    item.valid <= 1'b1;
    item.operation <= op;
    item.sender_id <= a;
    item.sender_state <= s;
    item.expiry_time <= t;
    item.hops <= h;
    item.gossip <= g;
    item.ticks <= tk;
    item.check_hops <= chk;
    item.entry_index <= k;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    table_model.note_request(op, a, s, t, h, g, tk, chk, k);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    item.valid <= 1'b0;
    repeat ($urandom_range(1, 20)) @(negedge clk);
  endtask

  // Waits until every queued result has arrived, then for the block to settle.
  task automatic drain();
    item.valid <= 1'b0;
    while (table_model.pending.size() != 0) @(negedge clk);
    repeat (900) @(negedge clk);
  endtask

  task automatic random_request();
    logic [2:0] op;
    logic [31:0] t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) op = enmt_pkg::OP_INSERT;
    else if (r < 50) op = enmt_pkg::OP_AGE;
    else if (r < 58) op = enmt_pkg::OP_SUB;
    else if (r < 70) op = enmt_pkg::OP_ERASE;
    else if (r < 85) op = enmt_pkg::OP_SELECT;
    else if (r < 97) op = enmt_pkg::OP_MARK;
    else op = 3'($urandom_range(6, 7));
    // Small counters make expiry and ties likely; occasionally any value.
    t = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
    send_request(op,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : agent_pool[$urandom_range(0, 3)],
                 ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                 t,
                 ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                 1'($urandom),
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3),
                 1'($urandom),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16)));
  endtask

  // One phase of random requests, sent in bursts that are mostly separated by gaps.
  task automatic random_phase(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
        random_request();
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
  endtask

  initial begin
    table_model = new();
    cycle_count = 0;
    stall_heavy = 0;
    agent_pool = '{8'd0, 8'd255, 8'd7, 8'd42};
    rst = 1'b1;
    item.valid = 1'b0;
    item.operation = enmt_pkg::OP_INSERT;
    item.sender_id = '0;
    item.sender_state = '0;
    item.expiry_time = '0;
    item.hops = '0;
    item.gossip = 1'b0;
    item.ticks = '0;
    item.check_hops = 1'b0;
    item.entry_index = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: empty table cases, extremes, every operation.
    send_request(enmt_pkg::OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_MARK, 0, 0, 0, 0, 0, 0, 0, 8'd255);
    send_request(enmt_pkg::OP_INSERT, 8'd255, 8'd255, 32'hFFFF_FFFF, 8'd255, 1, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd0, 8'd0, 32'd0, 8'd0, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_AGE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_SELECT, 0, 0, 0, 0, 0, 0, 1, 0);
    send_request(enmt_pkg::OP_SUB, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(enmt_pkg::OP_ERASE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_MARK, 0, 0, 0, 0, 0, 0, 0, 8'd1);
    send_request(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Small capacity with expiry and matching: full-table eviction, refresh refusals.
    write_reg(enmt_pkg::CFG_EXPIRY, 8'd1);
    write_reg(enmt_pkg::CFG_MATCH, 8'd1);
    write_reg(enmt_pkg::CFG_CAPACITY, 8'd2);
    send_request(enmt_pkg::OP_INSERT, 8'd5, 8'd1, 32'd3, 8'd2, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd5, 8'd1, 32'd9, 8'd2, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd5, 8'd2, 32'd9, 8'd3, 1, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd5, 8'd2, 32'd1, 8'd1, 1, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd6, 8'd1, 32'd0, 8'd1, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd7, 8'd1, 32'd4, 8'd0, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_SELECT, 0, 0, 0, 0, 0, 0, 1, 0);
    send_request(enmt_pkg::OP_SUB, 0, 0, 0, 0, 0, 32'd2, 0, 0);
    send_request(enmt_pkg::OP_ERASE, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
    // Capacity zero is taken as one; values above the depth as the depth.
    write_reg(enmt_pkg::CFG_CAPACITY, 8'd0);
    send_request(enmt_pkg::OP_INSERT, 8'd1, 8'd1, 32'd0, 8'd1, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_INSERT, 8'd2, 8'd1, 32'd0, 8'd1, 0, 0, 0, 0);
    drain();
    write_reg(enmt_pkg::CFG_CAPACITY, 8'd31);
    write_reg(enmt_pkg::CFG_PRIORITY, 8'd255);
    send_request(enmt_pkg::OP_INSERT, 8'd1, 8'd1, 32'd0, 8'd1, 0, 0, 0, 0);
    send_request(enmt_pkg::OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases across register settings, the extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(enmt_pkg::CFG_EXPIRY, 8'(ph[0]));
      write_reg(enmt_pkg::CFG_MATCH, 8'(ph[1]));
      write_reg(enmt_pkg::CFG_PRIORITY, (ph == 7) ? 8'd255 : 8'($urandom_range(0, 3)));
      write_reg(enmt_pkg::CFG_CAPACITY,
                (ph == 2) ? 8'd1 : (ph == 5) ? 8'd16 : 8'($urandom_range(2, 16)));
      stall_heavy = ph[2];
      random_phase(100);
      drain();
    end

    if (table_model.errors == 0 && table_model.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/enmt_pkg.sv
hdl/enmt_if.sv
hdl/enmt_ram.sv
hdl/enmt_ctl.sv
hdl/enmt_dp.sv
hdl/expiring_neighbour_message_table.sv
test/enmt_tb_scoreboard.sv
test/expiring_neighbour_message_table_tb.sv
